// ===== design/parallel_io_port_controller_assert.svh =====
// Assertion macros for the parallel I/O port controller checker.
`ifndef PARALLEL_IO_PORT_CONTROLLER_ASSERT_SVH
`define PARALLEL_IO_PORT_CONTROLLER_ASSERT_SVH

// The property holds in the same cycle as its antecedent.
`define PIO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The property holds in the cycle after its antecedent.
`define PIO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pio_pkg.sv =====
// Package with the types, codes and port state functions of the parallel I/O controller.
`timescale 1ns / 1ps
`default_nettype none

package pio_pkg;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_STROBE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_OUT    = 2'd0,
    MODE_IN     = 2'd1,
    MODE_BIDIR  = 2'd2,
    MODE_BITCTL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    NEXT_ANY  = 2'd0,
    NEXT_DIR  = 2'd1,
    NEXT_MASK = 2'd2
  } next_t;

  typedef enum logic [1:0] {
    SENSE_OR_LOW   = 2'd0,
    SENSE_OR_HIGH  = 2'd1,
    SENSE_AND_LOW  = 2'd2,
    SENSE_AND_HIGH = 2'd3
  } sense_t;

  localparam logic [3:0] CW_MODE   = 4'hf;
  localparam logic [3:0] CW_ICW    = 4'h7;
  localparam logic [3:0] CW_ENABLE = 4'h3;
  localparam int unsigned ICW_ENABLE_BIT = 7;
  localparam int unsigned ICW_MASK_BIT   = 4;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  icw;
    logic        ien;
    logic        ipend;
    logic        matched;
    logic [7:0]  dir;
    logic [7:0]  mask;
    logic [7:0]  olat;
    logic [7:0]  ilat;
    logic        rdy;
    logic        stb;
    next_t       nxt;
    logic [7:0]  vec;
  } port_t;

  typedef port_t [1:0] ports_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] drive_a;
    logic       drive_a_valid;
    logic [7:0] drive_b;
    logic       drive_b_valid;
    logic       ready_a;
    logic       ready_b;
    logic       int_req;
  } result_t;

  localparam port_t PORT_RST = '{
    mode:    MODE_IN,
    icw:     8'h00,
    ien:     1'b0,
    ipend:   1'b0,
    matched: 1'b0,
    dir:     8'h00,
    mask:    8'hff,
    olat:    8'h00,
    ilat:    8'h00,
    rdy:     1'b0,
    stb:     1'b0,
    nxt:     NEXT_ANY,
    vec:     8'h00
  };

  // Bit-control match of one port; a new match sets the pending flag.
  function automatic port_t port_eval(port_t s);
    port_t      r;
    logic [7:0] data;
    logic [7:0] m;
    logic       hit;
    r    = s;
    m    = ~s.mask;
    data = ((s.ilat & s.dir) | (s.olat & ~s.dir)) & m;
    case (sense_t'(s.icw[6:5]))
      SENSE_OR_LOW:  hit = (data != m);
      SENSE_OR_HIGH: hit = (data != 8'h00);
      SENSE_AND_LOW: hit = (data == 8'h00);
      default:       hit = (data == m);
    endcase
    if (s.mode == MODE_BITCTL) begin
      if (!s.matched && hit) begin
        r.ipend = 1'b1;
      end
      r.matched = hit;
    end
    return r;
  endfunction

  function automatic ports_t eval_all(ports_t s);
    ports_t r;
    r[0] = port_eval(s[0]);
    r[1] = port_eval(s[1]);
    return r;
  endfunction

  function automatic logic irq_of(ports_t s);
    return (s[0].ien & s[0].ipend) | (s[1].ien & s[1].ipend);
  endfunction

endpackage

`default_nettype wire

// ===== design/pio_if.sv =====
// Channel interfaces for the input and result beats of the parallel I/O controller.
`timescale 1ns / 1ps
`default_nettype none

interface pio_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] address;
  logic [7:0] wdata;
  logic       strobe_level;
  logic [7:0] pins_a;
  logic [7:0] pins_b;

  modport source (
    output valid, func, address, wdata, strobe_level, pins_a, pins_b,
    input  ready
  );
  modport sink (
    input  valid, func, address, wdata, strobe_level, pins_a, pins_b,
    output ready
  );
endinterface

interface pio_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic [7:0] drive_a;
  logic       drive_a_valid;
  logic [7:0] drive_b;
  logic       drive_b_valid;
  logic       ready_a;
  logic       ready_b;
  logic       int_req;

  modport source (
    output valid, rdata, drive_a, drive_a_valid, drive_b, drive_b_valid,
           ready_a, ready_b, int_req,
    input  ready
  );
  modport sink (
    input  valid, rdata, drive_a, drive_a_valid, drive_b, drive_b_valid,
           ready_a, ready_b, int_req,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/parallel_io_port_controller.sv =====
// Two-port parallel I/O controller: bus reads, bus writes and strobe events.
// Each input beat on in_ch is one bus read, one bus write or one strobe level
// change, carried with the current pin values of both ports. Every input beat
// yields exactly one result beat on out_ch with the read data, the values
// driven onto the port pins during that beat, both ready levels and the
// interrupt request level.
// The result of a beat accepted at one clock edge is registered and presented
// from the next edge on. Throughput is one beat per cycle while the receiver
// takes results; all work happens in the logic between the port state
// registers and the result register.
// When the receiver stalls, the result register holds its beat and in_ch.ready
// drops until that beat is taken, so no result is lost or repeated.
// A synchronous reset puts both ports in input mode with the mask at all ones,
// clears all other state and the interrupt request, and empties the result
// register.
`timescale 1ns / 1ps
`default_nettype none

module parallel_io_port_controller
  import pio_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  pio_in_if.sink      in_ch,
  pio_out_if.source   out_ch
);

  ports_t          state_r;
  ports_t          state_nxt;
  logic            int_line_r;
  logic            int_line_nxt;
  result_t         res_r;
  result_t         res_nxt;
  logic            out_valid_r;
  logic            accept;
  logic            p;
  logic [1:0][7:0] pins;
  logic [1:0][7:0] drv_val;
  logic [1:0]      drv_hit;
  logic [7:0]      rd;
  logic [7:0]      wd;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign p           = in_ch.address[0];
  assign wd          = in_ch.wdata;
  assign pins        = {in_ch.pins_b, in_ch.pins_a};

  always_comb begin
    state_nxt    = state_r;
    int_line_nxt = int_line_r;
    drv_val      = '0;
    drv_hit      = '0;
    rd           = 8'h00;
    unique case (func_t'(in_ch.func))
      FUNC_READ: begin
        if (in_ch.address[1]) begin
          rd = {state_r[0].icw[7:6], 2'b00, state_r[1].icw[7:4]};
        end else begin
          unique case (state_r[p].mode)
            MODE_OUT: begin
              rd = state_r[p].olat;
            end
            MODE_IN: begin
              if (!state_r[p].stb) begin
                state_nxt[p].ilat = pins[p];
              end
              rd                = state_nxt[p].ilat;
              state_nxt[p].rdy  = 1'b1;
            end
            MODE_BIDIR: begin
              rd               = state_r[p].ilat;
              state_nxt[1].rdy = 1'b1;
            end
            MODE_BITCTL: begin
              state_nxt[p].ilat = pins[p];
              rd = (pins[p] & state_r[p].dir) | (state_r[p].olat & ~state_r[p].dir);
            end
          endcase
        end
      end
      FUNC_WRITE: begin
        if (in_ch.address[1]) begin
          unique case (state_r[p].nxt)
            NEXT_ANY: begin
              if (!wd[0]) begin
                state_nxt[p].vec                 = wd;
                state_nxt[p].icw[ICW_ENABLE_BIT] = 1'b1;
                state_nxt[p].ien                 = 1'b1;
                state_nxt                        = eval_all(state_nxt);
                int_line_nxt                     = irq_of(state_nxt);
              end else if (wd[3:0] == CW_MODE) begin
                unique case (mode_t'(wd[7:6]))
                  MODE_OUT: begin
                    drv_val[p]        = state_r[p].olat;
                    drv_hit[p]        = 1'b1;
                    state_nxt[p].rdy  = 1'b1;
                    state_nxt[p].mode = MODE_OUT;
                  end
                  MODE_IN: begin
                    state_nxt[p].mode = MODE_IN;
                  end
                  MODE_BIDIR: begin
                    if (!p) begin
                      state_nxt[p].mode = MODE_BIDIR;
                    end
                  end
                  MODE_BITCTL: begin
                    if (!p || state_r[0].mode != MODE_BIDIR) begin
                      state_nxt[p].rdy = 1'b0;
                    end
                    state_nxt[p].ien     = 1'b0;
                    state_nxt            = eval_all(state_nxt);
                    int_line_nxt         = irq_of(state_nxt);
                    state_nxt[p].matched = 1'b0;
                    state_nxt[p].nxt     = NEXT_DIR;
                    state_nxt[p].mode    = MODE_BITCTL;
                  end
                endcase
              end else if (wd[3:0] == CW_ICW) begin
                state_nxt[p].icw = wd;
                if (wd[ICW_MASK_BIT]) begin
                  state_nxt[p].ien     = 1'b0;
                  state_nxt[p].ipend   = 1'b0;
                  state_nxt            = eval_all(state_nxt);
                  int_line_nxt         = irq_of(state_nxt);
                  state_nxt[p].matched = 1'b0;
                  state_nxt[p].nxt     = NEXT_MASK;
                end
              end else if (wd[3:0] == CW_ENABLE) begin
                state_nxt[p].icw[ICW_ENABLE_BIT] = wd[ICW_ENABLE_BIT];
                state_nxt[p].ien                 = wd[ICW_ENABLE_BIT];
                state_nxt                        = eval_all(state_nxt);
                int_line_nxt                     = irq_of(state_nxt);
              end
            end
            NEXT_DIR, NEXT_MASK: begin
              if (state_r[p].nxt == NEXT_DIR) begin
                state_nxt[p].dir = wd;
              end else begin
                state_nxt[p].mask = wd;
              end
              state_nxt[p].ien = state_r[p].icw[ICW_ENABLE_BIT];
              state_nxt        = eval_all(state_nxt);
              int_line_nxt     = irq_of(state_nxt);
              state_nxt[p].nxt = NEXT_ANY;
            end
            default: begin
            end
          endcase
        end else begin
          state_nxt[p].olat = wd;
          unique case (state_r[p].mode)
            MODE_OUT: begin
              drv_val[p]       = wd;
              drv_hit[p]       = 1'b1;
              state_nxt[p].rdy = 1'b1;
            end
            MODE_IN: begin
            end
            MODE_BIDIR: begin
              if (!state_r[p].stb) begin
                drv_val[p] = wd;
                drv_hit[p] = 1'b1;
              end
              state_nxt[p].rdy = 1'b1;
            end
            MODE_BITCTL: begin
              drv_val[p] = state_r[p].dir | (wd & ~state_r[p].dir);
              drv_hit[p] = 1'b1;
            end
          endcase
        end
      end
      FUNC_STROBE: begin
        if (state_r[0].mode == MODE_BIDIR) begin
          if (state_r[p].rdy) begin
            if (state_r[p].stb && !in_ch.strobe_level) begin
              if (!p) begin
                drv_val[0] = state_r[0].olat;
                drv_hit[0] = 1'b1;
              end else begin
                state_nxt[0].ilat = pins[0];
              end
            end else if (!state_r[p].stb && in_ch.strobe_level) begin
              state_nxt[p].ipend = 1'b1;
              state_nxt          = eval_all(state_nxt);
              int_line_nxt       = irq_of(state_nxt);
              state_nxt[p].rdy   = 1'b0;
            end
          end
        end else if (state_r[p].mode == MODE_OUT) begin
          if (state_r[p].rdy && !state_r[p].stb && in_ch.strobe_level) begin
            state_nxt[p].ipend = 1'b1;
            state_nxt          = eval_all(state_nxt);
            int_line_nxt       = irq_of(state_nxt);
            state_nxt[p].rdy   = 1'b0;
          end
        end else if (state_r[p].mode == MODE_IN) begin
          if (!in_ch.strobe_level) begin
            state_nxt[p].ilat = pins[p];
          end else if (!state_r[p].stb) begin
            state_nxt[p].ipend = 1'b1;
            state_nxt          = eval_all(state_nxt);
            int_line_nxt       = irq_of(state_nxt);
            state_nxt[p].rdy   = 1'b0;
          end
        end
        state_nxt[p].stb = in_ch.strobe_level;
      end
      FUNC_NONE: begin
      end
    endcase

    res_nxt.rdata         = rd;
    res_nxt.drive_a       = drv_val[0];
    res_nxt.drive_a_valid = drv_hit[0];
    res_nxt.drive_b       = drv_val[1];
    res_nxt.drive_b_valid = drv_hit[1];
    res_nxt.ready_a       = state_nxt[0].rdy;
    res_nxt.ready_b       = state_nxt[1].rdy;
    res_nxt.int_req       = int_line_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= {PORT_RST, PORT_RST};
      int_line_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        int_line_r  <= int_line_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rdata         = res_r.rdata;
  assign out_ch.drive_a       = res_r.drive_a;
  assign out_ch.drive_a_valid = res_r.drive_a_valid;
  assign out_ch.drive_b       = res_r.drive_b;
  assign out_ch.drive_b_valid = res_r.drive_b_valid;
  assign out_ch.ready_a       = res_r.ready_a;
  assign out_ch.ready_b       = res_r.ready_b;
  assign out_ch.int_req       = res_r.int_req;

endmodule

`default_nettype wire

// ===== design/pio_checker.sv =====
// Port-level checker for the parallel I/O controller and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

`include "parallel_io_port_controller_assert.svh"

module pio_checker
  import pio_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_func,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_rdata,
  input wire logic [7:0] out_drive_a,
  input wire logic       out_drive_a_valid,
  input wire logic       out_drive_b_valid
);

  logic in_beat;

  assign in_beat = in_valid && in_ready;

  // A stalled result beat keeps its read data and port A value unchanged.
  `PIO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rdata) && $stable(out_drive_a), "stalled result beat changed")

  // Only a bus read returns nonzero read data.
  `PIO_ASSERT_NEXT(a_rdata_zero, in_beat && in_func != FUNC_READ, out_valid && out_rdata == 8'h00, "read data on a beat that was not a read")

  // Port B is driven only by a bus write.
  `PIO_ASSERT_NEXT(a_drive_b_src, in_beat && in_func != FUNC_WRITE, out_valid && !out_drive_b_valid, "port B driven without a bus write")

  // An undriven port A reports zero.
  `PIO_ASSERT_SAME(a_drive_a_zero, out_valid && !out_drive_a_valid, out_drive_a == 8'h00, "port A value without a drive")

endmodule

bind parallel_io_port_controller pio_checker u_pio_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_func           (in_ch.func),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_rdata         (out_ch.rdata),
  .out_drive_a       (out_ch.drive_a),
  .out_drive_a_valid (out_ch.drive_a_valid),
  .out_drive_b_valid (out_ch.drive_b_valid)
);

`default_nettype wire

// ===== tb/parallel_io_port_controller_tb.sv =====
// Self-checking testbench for the parallel I/O controller, with predicted results per beat.
`timescale 1ns / 1ps

module parallel_io_port_controller_tb;
  import pio_pkg::*;

  localparam int RANDOM_ITEMS   = 320;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct {
    func_t      func;
    logic [1:0] address;
    logic [7:0] wdata;
    logic       lvl;
    logic [7:0] pins_a;
    logic [7:0] pins_b;
    bit         drain;
  } access_t;

  logic clk;
  logic rst_n;

  pio_in_if  in_ch ();
  pio_out_if out_ch ();

  parallel_io_port_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  access_t pending_accesses[$];
  result_t predicted_results[$];
  access_t on_bus;
  int      beats_in;
  int      beats_out;
  int      total_beats;
  int      errors;
  int      stall_cycles;

  // Predicted port state, index 0 is port A and index 1 is port B.
  mode_t      pmode   [2];
  logic [7:0] icw     [2];
  bit         ien     [2];
  bit         ipend   [2];
  bit         matched [2];
  logic [7:0] dirb    [2];
  logic [7:0] maskb   [2];
  logic [7:0] olat    [2];
  logic [7:0] ilat    [2];
  bit         rdy     [2];
  bit         stb     [2];
  next_t      nxt     [2];
  logic [7:0] vec     [2];
  bit         irq_line;
  logic [7:0] pins_now [2];
  logic [7:0] drv_val  [2];
  bit         drv_hit  [2];

  function automatic void present(int p, logic [7:0] v);
    drv_val[p] = v;
    drv_hit[p] = 1'b1;
  endfunction

  function automatic bit port_irq(int p);
    logic [7:0] data;
    logic [7:0] m;
    bit         hit;
    if (pmode[p] == MODE_BITCTL) begin
      m    = ~maskb[p];
      data = ((ilat[p] & dirb[p]) | (olat[p] & ~dirb[p])) & m;
      case (sense_t'(icw[p][6:5]))
        SENSE_OR_LOW:  hit = (data != m);
        SENSE_OR_HIGH: hit = (data != 8'h00);
        SENSE_AND_LOW: hit = (data == 8'h00);
        default:       hit = (data == m);
      endcase
      if (!matched[p] && hit) begin
        ipend[p] = 1'b1;
      end
      matched[p] = hit;
    end
    return ien[p] && ipend[p];
  endfunction

  // Both ports are always evaluated, since evaluation updates the match flags.
  function automatic void refresh_irq();
    bit a;
    bit b;
    a        = port_irq(0);
    b        = port_irq(1);
    irq_line = a | b;
  endfunction

  function automatic void enter_mode(int p, mode_t m);
    case (m)
      MODE_OUT: begin
        present(p, olat[p]);
        rdy[p]   = 1'b1;
        pmode[p] = MODE_OUT;
      end
      MODE_IN: begin
        pmode[p] = MODE_IN;
      end
      MODE_BIDIR: begin
        if (p == 0) begin
          pmode[p] = MODE_BIDIR;
        end
      end
      default: begin
        if (p == 0 || pmode[0] != MODE_BIDIR) begin
          rdy[p] = 1'b0;
        end
        ien[p] = 1'b0;
        refresh_irq();
        matched[p] = 1'b0;
        nxt[p]     = NEXT_DIR;
        pmode[p]   = MODE_BITCTL;
      end
    endcase
  endfunction

  function automatic void strobe_edge(int p, logic lvl);
    if (pmode[0] == MODE_BIDIR) begin
      if (rdy[p]) begin
        if (stb[p] && !lvl) begin
          if (p == 0) begin
            present(0, olat[0]);
          end else begin
            ilat[0] = pins_now[0];
          end
        end else if (!stb[p] && lvl) begin
          ipend[p] = 1'b1;
          refresh_irq();
          rdy[p] = 1'b0;
        end
      end
    end else if (pmode[p] == MODE_OUT) begin
      if (rdy[p] && !stb[p] && lvl) begin
        ipend[p] = 1'b1;
        refresh_irq();
        rdy[p] = 1'b0;
      end
    end else if (pmode[p] == MODE_IN) begin
      if (!lvl) begin
        ilat[p] = pins_now[p];
      end else if (!stb[p]) begin
        ipend[p] = 1'b1;
        refresh_irq();
        rdy[p] = 1'b0;
      end
    end
    stb[p] = lvl;
  endfunction

  function automatic void ctrl_write(int p, logic [7:0] v);
    case (nxt[p])
      NEXT_ANY: begin
        if (!v[0]) begin
          vec[p]                 = v;
          icw[p][ICW_ENABLE_BIT] = 1'b1;
          ien[p]                 = 1'b1;
          refresh_irq();
        end else if (v[3:0] == CW_MODE) begin
          enter_mode(p, mode_t'(v[7:6]));
        end else if (v[3:0] == CW_ICW) begin
          icw[p] = v;
          if (v[ICW_MASK_BIT]) begin
            ien[p]   = 1'b0;
            ipend[p] = 1'b0;
            refresh_irq();
            matched[p] = 1'b0;
            nxt[p]     = NEXT_MASK;
          end
        end else if (v[3:0] == CW_ENABLE) begin
          icw[p][ICW_ENABLE_BIT] = v[7];
          ien[p]                 = v[7];
          refresh_irq();
        end
      end
      NEXT_DIR, NEXT_MASK: begin
        if (nxt[p] == NEXT_DIR) begin
          dirb[p] = v;
        end else begin
          maskb[p] = v;
        end
        ien[p] = icw[p][ICW_ENABLE_BIT];
        refresh_irq();
        nxt[p] = NEXT_ANY;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] data_rd(int p);
    logic [7:0] d;
    d = 8'h00;
    case (pmode[p])
      MODE_OUT: begin
        d = olat[p];
      end
      MODE_IN: begin
        if (!stb[p]) begin
          ilat[p] = pins_now[p];
        end
        d      = ilat[p];
        rdy[p] = 1'b1;
      end
      MODE_BIDIR: begin
        d      = ilat[p];
        rdy[1] = 1'b1;
      end
      default: begin
        ilat[p] = pins_now[p];
        d       = (ilat[p] & dirb[p]) | (olat[p] & ~dirb[p]);
      end
    endcase
    return d;
  endfunction

  function automatic void data_wr(int p, logic [7:0] v);
    olat[p] = v;
    case (pmode[p])
      MODE_OUT: begin
        present(p, v);
        rdy[p] = 1'b1;
      end
      MODE_IN: ;
      MODE_BIDIR: begin
        if (!stb[p]) begin
          present(p, v);
        end
        rdy[p] = 1'b1;
      end
      default: begin
        present(p, dirb[p] | (v & ~dirb[p]));
      end
    endcase
  endfunction

  function automatic result_t apply_access(access_t a);
    result_t    r;
    int         p;
    logic [7:0] rd;
    p           = int'(a.address[0]);
    rd          = 8'h00;
    pins_now[0] = a.pins_a;
    pins_now[1] = a.pins_b;
    drv_val     = '{default: 8'h00};
    drv_hit     = '{default: 1'b0};
    case (a.func)
      FUNC_READ: begin
        if (a.address[1]) begin
          rd = (icw[0] & 8'hc0) | (icw[1] >> 4);
        end else begin
          rd = data_rd(p);
        end
      end
      FUNC_WRITE: begin
        if (a.address[1]) begin
          ctrl_write(p, a.wdata);
        end else begin
          data_wr(p, a.wdata);
        end
      end
      FUNC_STROBE: begin
        strobe_edge(p, a.lvl);
      end
      default: ;
    endcase
    r.rdata         = rd;
    r.drive_a       = drv_hit[0] ? drv_val[0] : 8'h00;
    r.drive_a_valid = drv_hit[0];
    r.drive_b       = drv_hit[1] ? drv_val[1] : 8'h00;
    r.drive_b_valid = drv_hit[1];
    r.ready_a       = rdy[0];
    r.ready_b       = rdy[1];
    r.int_req       = irq_line;
    return r;
  endfunction

  function automatic void add_access(func_t f, logic [1:0] addr, logic [7:0] wd, logic lvl,
                                     logic [7:0] pa, logic [7:0] pb);
    access_t a;
    a.func    = f;
    a.address = addr;
    a.wdata   = wd;
    a.lvl     = lvl;
    a.pins_a  = pa;
    a.pins_b  = pb;
    a.drain   = 1'b0;
    pending_accesses.push_back(a);
  endfunction

  function automatic void add_rnd(func_t f, logic [1:0] addr, logic [7:0] wd, logic lvl);
    add_access(f, addr, wd, lvl, 8'($urandom), 8'($urandom));
  endfunction

  function automatic int unsigned idle_pct(bit sender, int n);
    if (n < total_beats / 3) begin
      return sender ? 38 : 60;
    end
    if (n < 2 * total_beats / 3) begin
      return sender ? 60 : 38;
    end
    return 0;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 50) begin
      $display("ERROR: %s", msg);
    end
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result beat %0d: %s is 0x%0h, predicted 0x%0h",
                                beats_out, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    bit send_now;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(apply_access(on_bus));
        beats_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        send_now = pending_accesses.size() != 0 &&
                   $urandom_range(99) >= idle_pct(1'b1, beats_in) &&
                   !(pending_accesses[0].drain && beats_out != beats_in);
        if (send_now) begin
          on_bus                = pending_accesses.pop_front();
          in_ch.func           <= on_bus.func;
          in_ch.address        <= on_bus.address;
          in_ch.wdata          <= on_bus.wdata;
          in_ch.strobe_level   <= on_bus.lvl;
          in_ch.pins_a         <= on_bus.pins_a;
          in_ch.pins_b         <= on_bus.pins_b;
          in_ch.valid          <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with no prediction", beats_out));
        end else begin
          want = predicted_results.pop_front();
          check_field("rdata", out_ch.rdata, want.rdata);
          check_field("drive_a", out_ch.drive_a, want.drive_a);
          check_field("drive_a_valid", {7'h00, out_ch.drive_a_valid},
                      {7'h00, want.drive_a_valid});
          check_field("drive_b", out_ch.drive_b, want.drive_b);
          check_field("drive_b_valid", {7'h00, out_ch.drive_b_valid},
                      {7'h00, want.drive_b_valid});
          check_field("ready_a", {7'h00, out_ch.ready_a}, {7'h00, want.ready_a});
          check_field("ready_b", {7'h00, out_ch.ready_b}, {7'h00, want.ready_b});
          check_field("int_req", {7'h00, out_ch.int_req}, {7'h00, want.int_req});
        end
        beats_out <= beats_out + 1;
      end
      out_ch.ready <= $urandom_range(99) >= idle_pct(1'b0, beats_out);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int    useful;
    int    pick;
    bit    port;
    mode_t m;
    bit    gen_lvl [2];
    logic  lvl;
    logic  [7:0] icw_word;

    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_READ;
    in_ch.address      = 2'd0;
    in_ch.wdata        = 8'h00;
    in_ch.strobe_level = 1'b0;
    in_ch.pins_a       = 8'h00;
    in_ch.pins_b       = 8'h00;
    out_ch.ready       = 1'b0;
    beats_in           = 0;
    beats_out          = 0;
    errors             = 0;
    stall_cycles       = 0;
    total_beats        = 0;
    irq_line           = 1'b0;
    gen_lvl            = '{default: 1'b0};
    for (int p = 0; p < 2; p++) begin
      pmode[p]   = MODE_IN;
      icw[p]     = 8'h00;
      ien[p]     = 1'b0;
      ipend[p]   = 1'b0;
      matched[p] = 1'b0;
      dirb[p]    = 8'h00;
      maskb[p]   = 8'hff;
      olat[p]    = 8'h00;
      ilat[p]    = 8'h00;
      rdy[p]     = 1'b0;
      stb[p]     = 1'b0;
      nxt[p]     = NEXT_ANY;
      vec[p]     = 8'h00;
    end

    // Directed opening: extreme pins, every access kind and the corner cases.
    add_access(FUNC_READ,   2'd0, 8'h00, 1'b0, 8'hff, 8'h00);
    add_access(FUNC_READ,   2'd1, 8'hff, 1'b1, 8'h00, 8'hff);
    add_access(FUNC_READ,   2'd2, 8'h00, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_NONE,   2'd3, 8'hff, 1'b1, 8'hff, 8'hff);
    add_access(FUNC_WRITE,  2'd3, 8'h8f, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd2, 8'h05, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd2, 8'h00, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd3, 8'hfe, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd2, 8'h0f, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd0, 8'hff, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_STROBE, 2'd0, 8'h00, 1'b1, 8'h00, 8'h00);
    add_access(FUNC_STROBE, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd3, 8'hcf, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd3, 8'h0f, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd3, 8'hf7, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd3, 8'hf0, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_STROBE, 2'd1, 8'h00, 1'b1, 8'h00, 8'hff);
    add_access(FUNC_WRITE,  2'd1, 8'ha5, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_READ,   2'd1, 8'h00, 1'b0, 8'h00, 8'hff);
    add_access(FUNC_WRITE,  2'd2, 8'h8f, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd0, 8'h3c, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_READ,   2'd0, 8'h00, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_STROBE, 2'd1, 8'h00, 1'b0, 8'h5a, 8'h00);
    add_access(FUNC_STROBE, 2'd0, 8'h00, 1'b1, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd2, 8'h03, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_WRITE,  2'd3, 8'h83, 1'b0, 8'h00, 8'h00);
    add_access(FUNC_READ,   2'd2, 8'h00, 1'b0, 8'h00, 8'h00);
    gen_lvl[0] = 1'b1;

    // Random part: mostly well-formed control sequences and port traffic.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      port = 1'($urandom);
      pick = $urandom_range(99);
      if (pick < 14) begin
        m = mode_t'($urandom_range(3));
        add_rnd(FUNC_WRITE, {1'b1, port}, {m, 2'($urandom), CW_MODE}, 1'($urandom));
        if (m == MODE_BITCTL) begin
          add_rnd(FUNC_WRITE, {1'b1, port}, 8'($urandom), 1'($urandom));
        end
      end else if (pick < 24) begin
        icw_word = {1'($urandom), 2'($urandom), 1'($urandom), CW_ICW};
        add_rnd(FUNC_WRITE, {1'b1, port}, icw_word, 1'($urandom));
        if (icw_word[ICW_MASK_BIT]) begin
          add_rnd(FUNC_WRITE, {1'b1, port}, 8'($urandom), 1'($urandom));
        end
      end else if (pick < 29) begin
        add_rnd(FUNC_WRITE, {1'b1, port}, {1'($urandom), 3'($urandom), CW_ENABLE},
                1'($urandom));
      end else if (pick < 34) begin
        add_rnd(FUNC_WRITE, {1'b1, port}, {7'($urandom), 1'b0}, 1'($urandom));
      end else if (pick < 54) begin
        add_rnd(FUNC_WRITE, {1'b0, port}, 8'($urandom), 1'($urandom));
      end else if (pick < 69) begin
        add_rnd(FUNC_READ, {1'b0, port}, 8'($urandom), 1'($urandom));
      end else if (pick < 89) begin
        lvl = ($urandom_range(9) < 8) ? !gen_lvl[port] : 1'($urandom);
        gen_lvl[port] = lvl;
        add_rnd(FUNC_STROBE, {1'($urandom), port}, 8'($urandom), lvl);
      end else if (pick < 93) begin
        add_rnd(FUNC_READ, {1'b1, port}, 8'($urandom), 1'($urandom));
      end else if (pick < 96) begin
        add_rnd(FUNC_NONE, 2'($urandom), 8'($urandom), 1'($urandom));
        continue;
      end else begin
        add_rnd(FUNC_WRITE, {1'b1, port}, 8'($urandom), 1'($urandom));
        continue;
      end
      useful++;
    end

    total_beats = pending_accesses.size();
    pending_accesses[total_beats / 3].drain     = 1'b1;
    pending_accesses[2 * total_beats / 3].drain = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_accesses.size() != 0 || in_ch.valid || beats_out != beats_in) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
                                predicted_results.size()));
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== parallel_io_port_controller.f =====
+incdir+design
design/pio_pkg.sv
design/pio_if.sv
design/parallel_io_port_controller.sv
design/pio_checker.sv
tb/parallel_io_port_controller_tb.sv
